[rtl/core/ppmfr_pkg.sv]
// Shared types, constants and arithmetic helpers for the face reconstruction pipeline.
// Used by ppmfr_qmul, ppmfr_limit and ppm_face_reconstruction_top.
// Depends on nothing.
`default_nettype none

package ppmfr_pkg;

   // Wide signed Q31.16 intermediate, large enough for every traced quantity.
   typedef logic signed [47:0] wide_type;
   // Signed Q16.16 operand with a raw range from -2^32 up to 2^32 - 1.
   typedef logic signed [32:0] coef_type;
   // Signed 32-bit face value.
   typedef logic signed [31:0] face_type;

   localparam wide_type ONE_Q    = 48'sd65536;
   localparam wide_type WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam wide_type WIDE_MIN = -48'sh7FFF_FFFF_FFFF;

   // Register index of the interpolation mode.
   localparam logic CSR_IDX_MODE = 1'b0;

   // Registered stages from an accepted transfer to its result strobe.
   localparam int PIPE_DEPTH = 12;

   // Bias that makes the dividend of div3_floor positive; a multiple of three.
   localparam wide_type DIV3_BIAS = 48'sd1649267441664;
   localparam wide_type DIV3_OFF  = 48'sd549755813888;

   // Floor division by three for values of magnitude below 2^38. The biased
   // value is split at bit 20; since 2^20 - 1 is a multiple of three, the
   // quotient is h*(2^20-1)/3 plus a narrow reciprocal division of h + l.
   function automatic wide_type div3_floor(input wide_type v);
      logic [40:0] w;
      logic [20:0] h;
      logic [19:0] l;
      logic [21:0] n;
      logic [45:0] nm;
      logic [40:0] q;
      w  = 41'(v + DIV3_BIAS);
      h  = w[40:20];
      l  = w[19:0];
      n  = {1'b0, h} + {2'b00, l};
      nm = 46'(n) * 46'd5592406;
      q  = 41'(41'(h) * 41'd349525) + 41'(nm[45:24]);
      return wide_type'({7'd0, q}) - DIV3_OFF;
   endfunction

   // Symmetric saturation of a grown sum to the intermediate range.
   function automatic wide_type sat_wide(input logic signed [48:0] x);
      if (x > 49'(WIDE_MAX)) begin
         return WIDE_MAX;
      end else if (x < 49'(WIDE_MIN)) begin
         return WIDE_MIN;
      end
      return x[47:0];
   endfunction

   // Saturation to the signed 32-bit result range.
   function automatic face_type sat_face(input logic signed [48:0] x);
      if (x > 49'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -49'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/ppmfr_qmul.sv]
// Two-stage Q16.16 multiplier with sign-magnitude rounding and saturation.
// Depends on ppmfr_pkg for the wide type and saturation limit.
`default_nettype none

module ppmfr_qmul (
   input  wire logic               clock,
   input  wire ppmfr_pkg::coef_type a_i,
   input  wire ppmfr_pkg::wide_type b_i,
   input  wire logic               half_i,
   output ppmfr_pkg::wide_type     p_o
);

   logic                       neg_ff;
   logic                       half_ff;
   logic [64:0]                pp_lo_ff;
   logic [48:0]                pp_hi_ff;
   logic [32:0]                mag_a;
   logic [47:0]                mag_b;
   logic [80:0]                prod;
   logic [80:0]                rnd;
   logic [80:0]                shifted;
   logic [47:0]                mag_r;
   ppmfr_pkg::wide_type        p_in;
   ppmfr_pkg::wide_type        p_ff;

   // Magnitudes of both operands.
   assign mag_a = a_i[32] ? 33'(-a_i) : 33'(a_i);
   assign mag_b = b_i[47] ? 48'(-b_i) : 48'(b_i);

   // First stage: two partial products over the low 32 and the high 16 bits of b.
   always_ff @(posedge clock) begin
      neg_ff   <= a_i[32] ^ b_i[47];
      half_ff  <= half_i;
      pp_lo_ff <= 65'(mag_a) * 65'(mag_b[31:0]);
      pp_hi_ff <= 49'(mag_a) * 49'(mag_b[47:32]);
   end

   // Second stage: sum, round half away from zero, shift and saturate.
   always_comb begin
      prod    = 81'(pp_lo_ff) + {pp_hi_ff, 32'd0};
      rnd     = prod + (half_ff ? 81'd65536 : 81'd32768);
      shifted = half_ff ? (rnd >> 17) : (rnd >> 16);
      if (shifted > 81'(ppmfr_pkg::WIDE_MAX)) begin
         mag_r = 48'(ppmfr_pkg::WIDE_MAX);
      end else begin
         mag_r = shifted[47:0];
      end
      p_in = neg_ff ? -ppmfr_pkg::wide_type'(mag_r) : ppmfr_pkg::wide_type'(mag_r);
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p_o = p_ff;

endmodule

`default_nettype wire

[rtl/core/ppmfr_limit.sv]
// Four-stage parabolic limiter: range clipping, extremum flattening, overshoot fixes, width and curvature.
// Depends on ppmfr_pkg for the wide type.
`default_nettype none

module ppmfr_limit (
   input  wire logic               clock,
   input  wire ppmfr_pkg::face_type vl_i,
   input  wire ppmfr_pkg::face_type vc_i,
   input  wire ppmfr_pkg::face_type vr_i,
   input  wire ppmfr_pkg::wide_type pr_raw_i,
   input  wire ppmfr_pkg::wide_type pl_raw_i,
   output ppmfr_pkg::wide_type     pr_o,
   output ppmfr_pkg::wide_type     pl_o,
   output ppmfr_pkg::wide_type     dd_o,
   output ppmfr_pkg::wide_type     p6_o
);

   ppmfr_pkg::wide_type vcw, vlw, vrw, lo_r, hi_r, lo_l, hi_l, prc, plc, a_d, b_d;
   ppmfr_pkg::wide_type pr1_in, pl1_in, pr1_ff, pl1_ff, vc1_ff;
   ppmfr_pkg::wide_type dd2, mm2, pl2_in, pr2_ff, pl2_ff, vc2_ff;
   ppmfr_pkg::wide_type dd3, mm3, pr3_in, pr3_ff, pl3_ff, vc3_ff;
   ppmfr_pkg::wide_type pr_ff, pl_ff, dd_ff, p6_ff;

   // Clip each face estimate to its neighbour range and flatten an extremum.
   always_comb begin
      vcw  = ppmfr_pkg::wide_type'(vc_i);
      vlw  = ppmfr_pkg::wide_type'(vl_i);
      vrw  = ppmfr_pkg::wide_type'(vr_i);
      lo_r = (vcw < vrw) ? vcw : vrw;
      hi_r = (vcw < vrw) ? vrw : vcw;
      lo_l = (vcw < vlw) ? vcw : vlw;
      hi_l = (vcw < vlw) ? vlw : vcw;
      prc  = (pr_raw_i > hi_r) ? hi_r : ((pr_raw_i < lo_r) ? lo_r : pr_raw_i);
      plc  = (pl_raw_i > hi_l) ? hi_l : ((pl_raw_i < lo_l) ? lo_l : pl_raw_i);
      a_d  = prc - vcw;
      b_d  = vcw - plc;
      if (a_d == 48'sd0 || b_d == 48'sd0 || (a_d[47] != b_d[47])) begin
         pr1_in = vcw;
         pl1_in = vcw;
      end else begin
         pr1_in = prc;
         pl1_in = plc;
      end
   end

   always_ff @(posedge clock) begin
      pr1_ff <= pr1_in;
      pl1_ff <= pl1_in;
      vc1_ff <= vcw;
   end

   // Overshoot on the left side: pull the left face in.
   always_comb begin
      dd2 = pr1_ff - pl1_ff;
      mm2 = (vc1_ff <<< 1) - pl1_ff - pr1_ff;
      if ((dd2 > 48'sd0 && 3 * mm2 > dd2) || (dd2 < 48'sd0 && 3 * mm2 < dd2)) begin
         pl2_in = 3 * vc1_ff - (pr1_ff <<< 1);
      end else begin
         pl2_in = pl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pr2_ff <= pr1_ff;
      pl2_ff <= pl2_in;
      vc2_ff <= vc1_ff;
   end

   // Overshoot on the right side, tested with the updated left face.
   always_comb begin
      dd3 = pr2_ff - pl2_ff;
      mm3 = (vc2_ff <<< 1) - pl2_ff - pr2_ff;
      if ((dd3 > 48'sd0 && 3 * mm3 < -dd3) || (dd3 < 48'sd0 && 3 * mm3 > -dd3)) begin
         pr3_in = 3 * vc2_ff - (pl2_ff <<< 1);
      end else begin
         pr3_in = pr2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pr3_ff <= pr3_in;
      pl3_ff <= pl2_ff;
      vc3_ff <= vc2_ff;
   end

   // Parabola width and curvature term.
   always_ff @(posedge clock) begin
      pr_ff <= pr3_ff;
      pl_ff <= pl3_ff;
      dd_ff <= pr3_ff - pl3_ff;
      p6_ff <= 3 * ((vc3_ff <<< 1) - pr3_ff - pl3_ff);
   end

   assign pr_o = pr_ff;
   assign pl_o = pl_ff;
   assign dd_o = dd_ff;
   assign p6_o = p6_ff;

endmodule

`default_nettype wire

[rtl/core/ppm_face_reconstruction_top.sv]
// Top level of the face reconstruction pipeline with its register port.
// Depends on ppmfr_pkg, ppmfr_qmul and ppmfr_limit.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------------------
//   request   | start, busy                | req_value_*, req_slope_*, req_bin_velocity,
//             |                            | req_dt_over_dx
//   response  | rsp_strobe                 | rsp_face_plus, rsp_face_minus
//   registers | csr_psel/penable/pwrite    | csr_paddr, csr_pwdata, csr_prdata
//
// One transfer is accepted in every cycle; busy is never raised.
// Each result passes the Courant, limiter and two tracing multiplier stages.
// Reset clears the valid bits and the mode register; data registers are not reset.
// The receiver cannot stall, so the pipeline advances in every cycle.
`default_nettype none

module ppm_face_reconstruction_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_value_left,
   input  wire logic [31:0] req_value_center,
   input  wire logic [31:0] req_value_right,
   input  wire logic [31:0] req_slope_left,
   input  wire logic [31:0] req_slope_center,
   input  wire logic [31:0] req_slope_right,
   input  wire logic [31:0] req_bin_velocity,
   input  wire logic [16:0] req_dt_over_dx,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_face_plus,
   output logic [31:0]      rsp_face_minus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic accept;
   logic csr_write;
   logic mode_ff;
   logic valid_ff [1:11];
   logic strobe_ff;
   logic md_ff    [1:11];

   ppmfr_pkg::face_type vl_ff [1:2];
   ppmfr_pkg::face_type vr_ff [1:2];
   ppmfr_pkg::face_type sc_ff [1:2];
   ppmfr_pkg::face_type vc_ff [1:4];
   ppmfr_pkg::wide_type xr_ff, xl_ff, pr_raw_ff, pl_raw_ff;
   ppmfr_pkg::coef_type cp_d_ff [3:9];
   ppmfr_pkg::coef_type cm_d_ff [3:9];
   ppmfr_pkg::coef_type kp_ff, km_ff, u_pos, u_neg, lin_ap, lin_am;
   ppmfr_pkg::wide_type cp_q, cm_q, lin_p_q, lin_m_q, mq_p, mq_m, tp_q, tm_q;
   ppmfr_pkg::wide_type pr_o, pl_o, dd_o, p6_o;
   ppmfr_pkg::wide_type pr_d_ff [7:11];
   ppmfr_pkg::wide_type pl_d_ff [7:11];
   ppmfr_pkg::wide_type dd_d_ff [7:8];
   ppmfr_pkg::wide_type ip_ff, im_ff;
   ppmfr_pkg::face_type lfp_ff [5:11];
   ppmfr_pkg::face_type lfm_ff [5:11];
   ppmfr_pkg::face_type fp_ff, fm_ff;
   ppmfr_pkg::wide_type d_wide;

   // Register port: one mode bit, writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == ppmfr_pkg::CSR_IDX_MODE) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write && csr_paddr[2] == ppmfr_pkg::CSR_IDX_MODE) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   // Request handshake; the pipeline never refuses a transfer.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 11; i++) begin
            valid_ff[i] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         valid_ff[1] <= accept;
         for (int i = 2; i <= 11; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         strobe_ff <= valid_ff[11];
      end
   end

   // Stage 1: face estimate numerators and operand capture.
   always_ff @(posedge clock) begin
      md_ff[1] <= mode_ff;
      for (int i = 2; i <= 11; i++) begin
         md_ff[i] <= md_ff[i-1];
      end
      vl_ff[1] <= req_value_left;
      vr_ff[1] <= req_value_right;
      sc_ff[1] <= req_slope_center;
      vc_ff[1] <= req_value_center;
      vl_ff[2] <= vl_ff[1];
      vr_ff[2] <= vr_ff[1];
      sc_ff[2] <= sc_ff[1];
      for (int i = 2; i <= 4; i++) begin
         vc_ff[i] <= vc_ff[i-1];
      end
      xr_ff <= 48'sd3 * (ppmfr_pkg::wide_type'($signed(req_value_right))
               + ppmfr_pkg::wide_type'($signed(req_value_center)))
               - (ppmfr_pkg::wide_type'($signed(req_slope_right))
               + ppmfr_pkg::wide_type'($signed(req_slope_center)));
      xl_ff <= 48'sd3 * (ppmfr_pkg::wide_type'($signed(req_value_center))
               + ppmfr_pkg::wide_type'($signed(req_value_left)))
               - (ppmfr_pkg::wide_type'($signed(req_slope_center))
               + ppmfr_pkg::wide_type'($signed(req_slope_left)));
   end

   // Stage 2: face estimates, each rounded division by six.
   always_ff @(posedge clock) begin
      pr_raw_ff <= ppmfr_pkg::div3_floor((xr_ff + 48'sd3) >>> 1);
      pl_raw_ff <= ppmfr_pkg::div3_floor((xl_ff + 48'sd3) >>> 1);
   end

   // Courant numbers from the split velocity.
   assign u_pos  = req_bin_velocity[31] ? 33'sd0 : 33'($signed(req_bin_velocity));
   assign u_neg  = req_bin_velocity[31] ? 33'($signed(req_bin_velocity)) : 33'sd0;
   assign d_wide = ppmfr_pkg::wide_type'({31'd0, req_dt_over_dx});

   ppmfr_qmul u_cp (.clock(clock), .a_i(u_pos), .b_i(d_wide), .half_i(1'b0), .p_o(cp_q));
   ppmfr_qmul u_cm (.clock(clock), .a_i(u_neg), .b_i(d_wide), .half_i(1'b0), .p_o(cm_q));

   // Courant numbers are kept for the tracing stages further down.
   always_ff @(posedge clock) begin
      cp_d_ff[3] <= cp_q[32:0];
      cm_d_ff[3] <= cm_q[32:0];
      for (int i = 4; i <= 9; i++) begin
         cp_d_ff[i] <= cp_d_ff[i-1];
         cm_d_ff[i] <= cm_d_ff[i-1];
      end
   end

   // Piecewise-linear faces.
   assign lin_ap = 33'sd65536 - $signed(cp_q[32:0]);
   assign lin_am = 33'sd65536 + $signed(cm_q[32:0]);

   ppmfr_qmul u_lin_p (.clock(clock), .a_i(lin_ap), .b_i(ppmfr_pkg::wide_type'(sc_ff[2])),
                       .half_i(1'b1), .p_o(lin_p_q));
   ppmfr_qmul u_lin_m (.clock(clock), .a_i(lin_am), .b_i(ppmfr_pkg::wide_type'(sc_ff[2])),
                       .half_i(1'b1), .p_o(lin_m_q));

   always_ff @(posedge clock) begin
      lfp_ff[5] <= ppmfr_pkg::sat_face(49'(vc_ff[4]) + 49'(lin_p_q));
      lfm_ff[5] <= ppmfr_pkg::sat_face(49'(vc_ff[4]) - 49'(lin_m_q));
      for (int i = 6; i <= 11; i++) begin
         lfp_ff[i] <= lfp_ff[i-1];
         lfm_ff[i] <= lfm_ff[i-1];
      end
   end

   // Parabolic limiter.
   ppmfr_limit u_limit (
      .clock    (clock),
      .vl_i     (vl_ff[2]),
      .vc_i     (vc_ff[2]),
      .vr_i     (vr_ff[2]),
      .pr_raw_i (pr_raw_ff),
      .pl_raw_i (pl_raw_ff),
      .pr_o     (pr_o),
      .pl_o     (pl_o),
      .dd_o     (dd_o),
      .p6_o     (p6_o)
   );

   // Curvature weights 1 - 2cp/3 and 1 + 2cm/3, rounded.
   always_ff @(posedge clock) begin
      kp_ff <= 33'(ppmfr_pkg::ONE_Q - ppmfr_pkg::div3_floor(
               (ppmfr_pkg::wide_type'(cp_d_ff[5]) <<< 1) + 48'sd1));
      km_ff <= 33'(ppmfr_pkg::ONE_Q + ppmfr_pkg::div3_floor(
               (ppmfr_pkg::wide_type'(cm_d_ff[5]) <<< 1) + 48'sd1));
   end

   ppmfr_qmul u_kp (.clock(clock), .a_i(kp_ff), .b_i(p6_o), .half_i(1'b0), .p_o(mq_p));
   ppmfr_qmul u_km (.clock(clock), .a_i(km_ff), .b_i(p6_o), .half_i(1'b0), .p_o(mq_m));

   // Limited faces and width wait for the tracing products.
   always_ff @(posedge clock) begin
      pr_d_ff[7] <= pr_o;
      pl_d_ff[7] <= pl_o;
      for (int i = 8; i <= 11; i++) begin
         pr_d_ff[i] <= pr_d_ff[i-1];
         pl_d_ff[i] <= pl_d_ff[i-1];
      end
      dd_d_ff[7] <= dd_o;
      dd_d_ff[8] <= dd_d_ff[7];
   end

   // Bracketed terms of the traced faces.
   always_ff @(posedge clock) begin
      ip_ff <= ppmfr_pkg::sat_wide(49'(dd_d_ff[8]) - 49'(mq_p));
      im_ff <= ppmfr_pkg::sat_wide(49'(dd_d_ff[8]) + 49'(mq_m));
   end

   ppmfr_qmul u_tp (.clock(clock), .a_i(cp_d_ff[9]), .b_i(ip_ff), .half_i(1'b1), .p_o(tp_q));
   ppmfr_qmul u_tm (.clock(clock), .a_i(cm_d_ff[9]), .b_i(im_ff), .half_i(1'b1), .p_o(tm_q));

   // Output register: method select and final saturation.
   always_ff @(posedge clock) begin
      if (md_ff[11]) begin
         fp_ff <= ppmfr_pkg::sat_face(49'(pr_d_ff[11]) - 49'(tp_q));
         fm_ff <= ppmfr_pkg::sat_face(49'(pl_d_ff[11]) + 49'(tm_q));
      end else begin
         fp_ff <= lfp_ff[11];
         fm_ff <= lfm_ff[11];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_face_plus  = fp_ff;
   assign rsp_face_minus = fm_ff;

`ifndef ASSERT_OFF
   // A result only ever follows an accepted transfer by the pipeline depth.
   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, ppmfr_pkg::PIPE_DEPTH))
      else $error("result strobe without a matching request");

   // Courant numbers keep the sign of their velocity half.
   a_cp_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> !cp_d_ff[3][32])
      else $error("positive Courant number went negative");

   a_cm_nonpos: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (cm_d_ff[3] <= 33'sd0))
      else $error("negative Courant number went positive");

   // Bracketed terms stay within the saturated range.
   a_ip_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[9] |-> (ip_ff != -48'sh8000_0000_0000 && im_ff != -48'sh8000_0000_0000))
      else $error("tracing term outside the saturated range");
`endif

endmodule

`default_nettype wire
